// ===== sv/aabb_pkg.sv =====
// Package for the box collision resolver: default sizes and command codes.
// No dependencies.
package aabb_pkg;

  localparam int MAX_BOXES_DEF  = 256;
  localparam int COORD_BITS_DEF = 32;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_RESOLVE = 1'b1;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

endpackage

// ===== sv/aabb_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module aabb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/aabb_collision_resolver_unit.sv =====
// Box collision resolver: keeps a table of boxes in one RAM and pushes a moving
// box out of the first enabled box it overlaps. A resolve beat walks the table,
// reading one table entry per cycle through the single RAM read port, and a
// finished result may wait on out_stall. The block takes one beat at a time; a
// result waits in an output register.
module aabb_collision_resolver_unit #(
  parameter int MAX_BOXES  = aabb_pkg::MAX_BOXES_DEF,
  parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [7:0]         in_entry_index,
  input  logic               in_axis,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic [30:0]        in_size_x,
  input  logic [30:0]        in_size_y,
  input  logic               in_enable,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_new_center,
  output logic               out_collides,
  output logic               out_grounded
);

  import aabb_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int NW = (CW > 9) ? CW : 9;
  localparam int EW = ((CB > 32) ? CB : 32) + 2;
  localparam int DW = 4 * CB + 1;
  localparam logic signed [EW-1:0] CMAX_E = EW'((64'sd1 <<< (CB - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] CMIN_E = -CMAX_E - EW'(1);
  localparam logic signed [EW-1:0] I32MAX_E = EW'(64'sd2147483647);
  localparam logic signed [EW-1:0] I32MIN_E = EW'(-64'sd2147483648);
  localparam logic [NW-1:0] MAXB_N = NW'(MAX_BOXES);

  typedef enum logic [3:0] {
    S_IDLE, S_WR, S_RDP, S_LDP, S_WALK, S_DELTA, S_CENTER, S_EXT, S_WB, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    HIT_NONE, HIT_C1, HIT_C2, HIT_C3, HIT_C4, HIT_S5, HIT_S6, HIT_S7, HIT_S8
  } hit_t;

  function automatic logic signed [CB-1:0] sat_c(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] t;
    t = v;
    if (v > CMAX_E) t = CMAX_E;
    else if (v < CMIN_E) t = CMIN_E;
    return t[CB-1:0];
  endfunction

  state_t state_r;
  logic [8:0] boxes_in_use_r;

  // captured beat
  logic               axis_r, en_in_r;
  logic [7:0]         idx_r;
  logic signed [31:0] cx_r, cy_r;
  logic [29:0]        hx_r, hy_r;
  logic [NW-1:0]      walk_len_r;

  // moving box
  logic signed [CB-1:0] p_l_r, p_r_r, p_b_r, p_t_r;
  logic                 p_en_r;
  logic signed [CB-1:0] c_r, nc_r;

  // walk
  logic [NW-1:0] iss_cnt_r;
  logic          pend_v_r;
  logic [AW-1:0] pend_idx_r;
  hit_t          hit_r;
  logic signed [CB-1:0] e_l_r, e_r_r, e_b_r, e_t_r;
  logic signed [EW-1:0] d_r;
  logic          coll_r, gnd_r;

  logic               out_valid_r, out_coll_r, out_gnd_r;
  logic signed [31:0] out_nc_r;

  // RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  aabb_ram #(.WIDTH(DW), .DEPTH(MAX_BOXES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [AW-1:0] idx_a;
  logic          idx_ok;
  logic signed [EW-1:0] cx_e, cy_e, hx_e, hy_e, c_e, nc_e;
  logic signed [CB-1:0] e_l, e_r, e_b, e_t;
  logic          e_en;
  hit_t          hit_c;
  logic          hit_gnd;
  logic          hit_now;
  logic signed [EW-1:0] d_c;
  logic signed [CB-1:0] lo_c, hi_c;

  assign idx_a  = AW'(idx_r);
  assign idx_ok = NW'(idx_r) < MAXB_N;
  assign cx_e   = EW'(cx_r);
  assign cy_e   = EW'(cy_r);
  assign hx_e   = $signed(EW'(hx_r));
  assign hy_e   = $signed(EW'(hy_r));
  assign c_e    = EW'(c_r);
  assign nc_e   = EW'(nc_r);

  assign e_l  = $signed(ram_rdata[CB-1:0]);
  assign e_r  = $signed(ram_rdata[2*CB-1:CB]);
  assign e_b  = $signed(ram_rdata[3*CB-1:2*CB]);
  assign e_t  = $signed(ram_rdata[4*CB-1:3*CB]);
  assign e_en = ram_rdata[DW-1];

  // eight overlap tests, first match wins
  always_comb begin
    hit_c   = HIT_NONE;
    hit_gnd = 1'b0;
    priority if (p_b_r < e_t && p_r_r > e_l && p_b_r > e_b && p_r_r < e_r) begin
      hit_c = HIT_C1; hit_gnd = 1'b1;
    end else if (p_t_r > e_b && p_r_r > e_l && p_t_r < e_t && p_r_r < e_r) begin
      hit_c = HIT_C2;
    end else if (p_t_r > e_b && p_l_r < e_r && p_t_r < e_t && p_l_r > e_l) begin
      hit_c = HIT_C3;
    end else if (p_b_r < e_t && p_l_r < e_r && p_b_r > e_b && p_l_r > e_l) begin
      hit_c = HIT_C4; hit_gnd = 1'b1;
    end else if (p_b_r <= e_b && p_t_r >= e_t && p_r_r > e_l && p_r_r < e_r) begin
      hit_c = HIT_S5;
    end else if (p_t_r >= e_t && p_b_r <= e_b && p_l_r < e_r && p_l_r > e_l) begin
      hit_c = HIT_S6; hit_gnd = 1'b1;
    end else if (p_l_r <= e_l && p_b_r < e_t && p_r_r >= e_r && p_b_r > e_b) begin
      hit_c = HIT_S7; hit_gnd = 1'b1;
    end else if (p_l_r <= e_l && p_t_r > e_b && p_r_r >= e_r && p_t_r < e_t) begin
      hit_c = HIT_S8;
    end else begin
      hit_c = HIT_NONE;
    end
  end

  assign hit_now = pend_v_r && e_en && (pend_idx_r != idx_a) && (hit_c != HIT_NONE);

  // push-out distance on the resolved axis
  always_comb begin
    d_c = '0;
    if (axis_r == AXIS_X) begin
      unique case (hit_r)
        HIT_C1, HIT_C2, HIT_S5: d_c = EW'(e_l_r) - EW'(p_r_r);
        HIT_C3, HIT_C4, HIT_S6: d_c = EW'(e_r_r) - EW'(p_l_r);
        default:                d_c = '0;
      endcase
    end else begin
      unique case (hit_r)
        HIT_C1, HIT_C4, HIT_S7: d_c = EW'(e_t_r) - EW'(p_b_r);
        HIT_C2, HIT_C3, HIT_S8: d_c = EW'(e_b_r) - EW'(p_t_r);
        default:                d_c = '0;
      endcase
    end
  end

  assign lo_c = (state_r == S_LDP) ? sat_c(c_e - hx_e) : sat_c(nc_e - hx_e);
  assign hi_c = (state_r == S_LDP) ? sat_c(c_e + hx_e) : sat_c(nc_e + hx_e);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_a;
    ram_wdata = {p_en_r, p_t_r, p_b_r, p_r_r, p_l_r};
    ram_raddr = (state_r == S_RDP) ? idx_a : iss_cnt_r[AW-1:0];
    if (state_r == S_WR) begin
      ram_we    = idx_ok;
      ram_wdata = {en_in_r, sat_c(cy_e + hy_e), sat_c(cy_e - hy_e),
                   sat_c(cx_e + hx_e), sat_c(cx_e - hx_e)};
    end else if (state_r == S_WB) begin
      ram_we = 1'b1;
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_new_center = out_nc_r;
  assign out_collides   = out_coll_r;
  assign out_grounded   = out_gnd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      boxes_in_use_r <= '0;
      out_valid_r    <= 1'b0;
      pend_v_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        boxes_in_use_r <= cfg_wdata;
      end
      // S_OUT drives out_valid_r itself
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            idx_r    <= in_entry_index;
            axis_r   <= in_axis;
            cx_r     <= in_center_x;
            cy_r     <= in_center_y;
            hx_r     <= in_size_x[30:1];
            hy_r     <= in_size_y[30:1];
            en_in_r  <= in_enable;
            coll_r   <= 1'b0;
            gnd_r    <= 1'b0;
            walk_len_r <= (NW'(boxes_in_use_r) < MAXB_N) ? NW'(boxes_in_use_r) : MAXB_N;
            state_r  <= (in_cmd == CMD_WRITE) ? S_WR : S_RDP;
          end
        end
        S_WR: state_r <= S_IDLE;
        S_RDP: begin
          c_r  <= sat_c(cx_e);
          nc_r <= sat_c(cx_e);
          state_r <= idx_ok ? S_LDP : S_OUT;
        end
        S_LDP: begin
          p_en_r <= e_en;
          if (axis_r == AXIS_X) begin
            p_l_r <= lo_c; p_r_r <= hi_c; p_b_r <= e_b; p_t_r <= e_t;
          end else begin
            p_l_r <= e_l; p_r_r <= e_r; p_b_r <= lo_c; p_t_r <= hi_c;
          end
          iss_cnt_r <= '0;
          pend_v_r  <= 1'b0;
          state_r   <= S_WALK;
        end
        S_WALK: begin
          if (hit_now) begin
            hit_r  <= hit_c;
            gnd_r  <= hit_gnd;
            coll_r <= 1'b1;
            e_l_r  <= e_l; e_r_r <= e_r; e_b_r <= e_b; e_t_r <= e_t;
            pend_v_r <= 1'b0;
            state_r  <= S_DELTA;
          end else if (iss_cnt_r < walk_len_r) begin
            iss_cnt_r  <= iss_cnt_r + NW'(1);
            pend_idx_r <= iss_cnt_r[AW-1:0];
            pend_v_r   <= 1'b1;
          end else begin
            pend_v_r <= 1'b0;
            if (!pend_v_r) begin
              state_r <= S_WB;
            end
          end
        end
        S_DELTA: begin
          d_r     <= d_c;
          state_r <= S_CENTER;
        end
        S_CENTER: begin
          nc_r    <= sat_c(c_e + d_r);
          state_r <= S_EXT;
        end
        S_EXT: begin
          if (axis_r == AXIS_X) begin
            p_l_r <= lo_c; p_r_r <= hi_c;
          end else begin
            p_b_r <= lo_c; p_t_r <= hi_c;
          end
          state_r <= S_WB;
        end
        S_WB: state_r <= S_OUT;
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_coll_r  <= coll_r;
            out_gnd_r   <= gnd_r;
            if (nc_e > I32MAX_E)      out_nc_r <= 32'sh7FFFFFFF;
            else if (nc_e < I32MIN_E) out_nc_r <= 32'sh80000000;
            else                      out_nc_r <= nc_e[31:0];
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> !ram_we)
    else $error("table written during walk");

  a_rose_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside output state");

  a_grounded_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_gnd_r || out_coll_r))
    else $error("grounded without a hit");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (iss_cnt_r <= walk_len_r))
    else $error("walk counter past walk length");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for aabb_collision_resolver_unit: directed table plus random
// write/resolve beats, checked against an in-bench box table predictor. Depends on aabb_pkg.
`timescale 1ns / 100ps
module tb_top;
  import aabb_pkg::*;

  localparam int NBOX = 256;
  localparam logic signed [63:0] CMAX = 64'sd2147483647;
  localparam logic signed [63:0] CMIN = -64'sd2147483648;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic              cmd;
    logic [7:0]        idx;
    logic              axis;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]       sx;
    logic [30:0]       sy;
    logic              en;
  } box_beat_t;

  typedef struct {
    logic signed [31:0] center;
    logic              col;
    logic              gr;
  } push_res_t;

  typedef struct {
    box_beat_t beat;
    logic      chk;
    push_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [8:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = CMD_WRITE;
  logic [7:0] in_entry_index = '0;
  logic in_axis = AXIS_X;
  logic signed [31:0] in_center_x = '0;
  logic signed [31:0] in_center_y = '0;
  logic [30:0] in_size_x = '0;
  logic [30:0] in_size_y = '0;
  logic in_enable = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_new_center;
  logic out_collides;
  logic out_grounded;

  always #5 clk = ~clk;

  aabb_collision_resolver_unit u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_entry_index(in_entry_index), .in_axis(in_axis), .in_center_x(in_center_x),
    .in_center_y(in_center_y), .in_size_x(in_size_x), .in_size_y(in_size_y),
    .in_enable(in_enable), .out_valid(out_valid), .out_stall(out_stall),
    .out_new_center(out_new_center), .out_collides(out_collides),
    .out_grounded(out_grounded)
  );

  // predictor copy of the box table and walk length
  logic signed [63:0] tb_l [NBOX];
  logic signed [63:0] tb_r [NBOX];
  logic signed [63:0] tb_b [NBOX];
  logic signed [63:0] tb_t [NBOX];
  logic              tb_en [NBOX];
  logic [8:0]        walk_len;

  push_res_t pending_pushes [$];
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;

  function automatic logic signed [63:0] clamp_coord(logic signed [63:0] v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  // updates the table; returns 1 with the expected push-out for a resolve beat
  function automatic bit resolve_box(box_beat_t it, output push_res_t res);
    logic signed [63:0] cx, cy, hx, hy, c, nc, dx, dy;
    logic signed [63:0] pl, pr, pb, pt, l, r, b, t;
    int walk;
    bit col, gr;
    cx = it.cx;
    cy = it.cy;
    hx = $signed({33'b0, it.sx >> 1});
    hy = $signed({33'b0, it.sy >> 1});
    c = cx;
    col = 0;
    gr = 0;
    if (it.cmd == CMD_WRITE) begin
      tb_l[it.idx] = clamp_coord(cx - hx);
      tb_r[it.idx] = clamp_coord(cx + hx);
      tb_b[it.idx] = clamp_coord(cy - hy);
      tb_t[it.idx] = clamp_coord(cy + hy);
      tb_en[it.idx] = it.en;
      return 0;
    end
    nc = c;
    if (it.axis == AXIS_X) begin
      tb_l[it.idx] = clamp_coord(c - hx);
      tb_r[it.idx] = clamp_coord(c + hx);
    end else begin
      tb_b[it.idx] = clamp_coord(c - hx);
      tb_t[it.idx] = clamp_coord(c + hx);
    end
    walk = (walk_len < NBOX) ? walk_len : NBOX;
    for (int i = 0; i < walk && !col; i++) begin
      if (i == it.idx || !tb_en[i]) continue;
      pl = tb_l[it.idx]; pr = tb_r[it.idx]; pb = tb_b[it.idx]; pt = tb_t[it.idx];
      l = tb_l[i]; r = tb_r[i]; b = tb_b[i]; t = tb_t[i];
      dx = 0;
      dy = 0;
      col = 1;
      if (pb < t && pr > l && pb > b && pr < r) begin
        dx = l - pr; dy = t - pb; gr = 1;
      end else if (pt > b && pr > l && pt < t && pr < r) begin
        dx = l - pr; dy = b - pt;
      end else if (pt > b && pl < r && pt < t && pl > l) begin
        dx = r - pl; dy = b - pt;
      end else if (pb < t && pl < r && pb > b && pl > l) begin
        dx = r - pl; dy = t - pb; gr = 1;
      end else if (pb <= b && pt >= t && pr > l && pr < r) begin
        dx = l - pr;
      end else if (pt >= t && pb <= b && pl < r && pl > l) begin
        dx = r - pl; gr = 1;
      end else if (pl <= l && pb < t && pr >= r && pb > b) begin
        dy = t - pb; gr = 1;
      end else if (pl <= l && pt > b && pr >= r && pt < t) begin
        dy = b - pt;
      end else begin
        col = 0;
      end
      if (col) begin
        nc = clamp_coord(c + ((it.axis == AXIS_X) ? dx : dy));
        if (it.axis == AXIS_X) begin
          tb_l[it.idx] = clamp_coord(nc - hx);
          tb_r[it.idx] = clamp_coord(nc + hx);
        end else begin
          tb_b[it.idx] = clamp_coord(nc - hx);
          tb_t[it.idx] = clamp_coord(nc + hx);
        end
      end
    end
    res.center = nc[31:0];
    res.col = col;
    res.gr = gr;
    return 1;
  endfunction

  task automatic queue_expect(push_res_t r);
    pending_pushes = {pending_pushes, r};
  endtask

  // drive one beat from a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(box_beat_t it, logic chk, push_res_t typed);
    push_res_t res;
    while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_cmd = it.cmd;
    in_entry_index = it.idx;
    in_axis = it.axis;
    in_center_x = it.cx;
    in_center_y = it.cy;
    in_size_x = it.sx;
    in_size_y = it.sy;
    in_enable = it.en;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (resolve_box(it, res)) begin
      queue_expect(res);
      if (chk && (res.center !== typed.center || res.col !== typed.col ||
                  res.gr !== typed.gr)) begin
        $display("%0t directed row mismatch: expected %h/%b/%b actual %h/%b/%b", $time,
                 typed.center, typed.col, typed.gr, res.center, res.col, res.gr);
        errors++;
      end
    end
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_pushes.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_walk_len(logic [8:0] v);
    wait_idle();
    cfg_we = 1'b1;
    cfg_wdata = v;
    walk_len = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1, 2: return int'($urandom_range(0, 2097151)) - 1048576;
      default: return (int'($urandom_range(0, 32)) - 16) <<< 15;
    endcase
  endfunction

  function automatic logic [30:0] rnd_size();
    case ($urandom_range(0, 9))
      0: return 31'($urandom);
      1, 2: return 31'($urandom_range(0, 1048575));
      default: return 31'($urandom_range(0, 12) << 15);
    endcase
  endfunction

  function automatic logic [7:0] rnd_index(int walk);
    int top;
    top = (walk + 3 > 255) ? 255 : walk + 3;
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, top));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic box_beat_t mk(logic cmd, int idx, logic axis, int cx, int cy,
                                   int sx, int sy, logic en);
    box_beat_t b;
    b.cmd = cmd; b.idx = 8'(idx); b.axis = axis; b.cx = cx; b.cy = cy;
    b.sx = 31'(sx); b.sy = 31'(sy); b.en = en;
    return b;
  endfunction

  // receiver side stall
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = (rx_idle_pct > 0) && ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    push_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pushes.size() == 0) begin
        $display("%0t unexpected result beat: actual %h/%b/%b", $time, out_new_center,
                 out_collides, out_grounded);
        errors++;
      end else begin
        e = pending_pushes.pop_front();
        if (out_new_center !== e.center || out_collides !== e.col ||
            out_grounded !== e.gr) begin
          $display("%0t result mismatch: expected %h/%b/%b actual %h/%b/%b", $time,
                   e.center, e.col, e.gr, out_new_center, out_collides, out_grounded);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  localparam int U = 65536;
  dir_row_t dir_rows [$];
  int seg_walk [8] = '{0, 16, 256, 511, 5, 1, 32, 3};

  task automatic add_row(box_beat_t b, logic chk, push_res_t r);
    dir_row_t row;
    row.beat = b;
    row.chk = chk;
    row.res = r;
    dir_rows = {dir_rows, row};
  endtask

  initial begin
    box_beat_t it;
    push_res_t none;
    push_res_t typed;
    none = '{center: '0, col: 1'b0, gr: 1'b0};
    walk_len = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // every entry gets written before anything reads it
    for (int i = 0; i < NBOX; i++)
      send_beat(mk(CMD_WRITE, i, AXIS_X, 0, 0, 0, 0, 1'b0), 1'b0, none);
    write_walk_len(9'd4);

    add_row(mk(CMD_WRITE, 0, AXIS_X, 0, 0, 4*U, 4*U, 1'b1), 1'b0, none);
    add_row(mk(CMD_WRITE, 1, AXIS_X, 32'h7fffffff, 32'h80000000,
               31'h7fffffff, 31'h7fffffff, 1'b0), 1'b0, none);
    add_row(mk(CMD_WRITE, 2, AXIS_X, 10*U, 0, 2*U, 2*U, 1'b1), 1'b0, none);
    // corner and side cases against the box at the origin
    add_row(mk(CMD_WRITE, 5, AXIS_X, -2*U, U, 2*U, 2*U, 1'b0), 1'b0, none);
    add_row(mk(CMD_RESOLVE, 5, AXIS_X, -2*U, 0, 2*U, 0, 1'b0), 1'b0, none);
    add_row(mk(CMD_WRITE, 5, AXIS_X, -2*U, -2*U, 2*U, 2*U, 1'b0), 1'b0, none);
    add_row(mk(CMD_RESOLVE, 5, AXIS_Y, -2*U, 0, 2*U, 0, 1'b0), 1'b0, none);
    add_row(mk(CMD_WRITE, 5, AXIS_X, 2*U, -2*U, 2*U, 2*U, 1'b0), 1'b0, none);
    add_row(mk(CMD_RESOLVE, 5, AXIS_X, 2*U, 0, 2*U, 0, 1'b0), 1'b0, none);
    add_row(mk(CMD_WRITE, 5, AXIS_X, 2*U, 2*U, 2*U, 2*U, 1'b0), 1'b0, none);
    add_row(mk(CMD_RESOLVE, 5, AXIS_Y, 2*U, 0, 2*U, 0, 1'b0), 1'b0, none);
    add_row(mk(CMD_WRITE, 5, AXIS_X, -2*U, 0, 2*U, 6*U, 1'b0), 1'b0, none);
    add_row(mk(CMD_RESOLVE, 5, AXIS_X, -2*U, 0, 2*U, 0, 1'b0), 1'b0, none);
    add_row(mk(CMD_WRITE, 5, AXIS_X, 2*U, 0, 2*U, 6*U, 1'b0), 1'b0, none);
    add_row(mk(CMD_RESOLVE, 5, AXIS_X, 2*U, 0, 2*U, 0, 1'b0), 1'b0, none);
    add_row(mk(CMD_WRITE, 5, AXIS_X, 0, 2*U, 6*U, 2*U, 1'b0), 1'b0, none);
    add_row(mk(CMD_RESOLVE, 5, AXIS_Y, 2*U, 0, 2*U, 0, 1'b0), 1'b0, none);
    add_row(mk(CMD_WRITE, 5, AXIS_X, 0, -2*U, 6*U, 2*U, 1'b0), 1'b0, none);
    add_row(mk(CMD_RESOLVE, 5, AXIS_Y, -2*U, 0, 2*U, 0, 1'b0), 1'b0, none);
    // extremes far from every enabled box: no hit, center passes through
    typed = '{center: 32'h7fffffff, col: 1'b0, gr: 1'b0};
    add_row(mk(CMD_RESOLVE, 255, AXIS_Y, 32'h7fffffff, 0, 31'h7fffffff,
               0, 1'b0), 1'b1, typed);
    typed = '{center: 32'h80000000, col: 1'b0, gr: 1'b0};
    add_row(mk(CMD_RESOLVE, 255, AXIS_X, 32'h80000000, 0, 0, 0, 1'b0), 1'b1, typed);
    foreach (dir_rows[k]) send_beat(dir_rows[k].beat, dir_rows[k].chk, dir_rows[k].res);

    for (int s = 0; s < 8; s++) begin
      write_walk_len(9'(seg_walk[s]));
      tx_idle_pct = (s < 3) ? 10 : (s < 6) ? 75 : 0;
      rx_idle_pct = (s < 3) ? 75 : (s < 6) ? 10 : 0;
      if (s == 1) hold_req = 1'b1;
      for (int n = 0; n < 65; n++) begin
        it.cmd = $urandom_range(0, 1) ? CMD_RESOLVE : CMD_WRITE;
        it.idx = rnd_index(seg_walk[s] > 255 ? 255 : seg_walk[s]);
        it.axis = $urandom_range(0, 1) ? AXIS_Y : AXIS_X;
        it.cx = rnd_coord();
        it.cy = rnd_coord();
        it.sx = rnd_size();
        it.sy = rnd_size();
        it.en = ($urandom_range(0, 3) != 0);
        send_beat(it, 1'b0, none);
      end
    end
    tx_idle_pct = 0;
    in_valid = 1'b0;
    while (pending_pushes.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0 && pending_pushes.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end
endmodule
